@@ sv/ttfb_pkg.sv @@
// Shared types and constants of the text terminal framebuffer.
`default_nettype none
package ttfb_pkg;
	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BS = 8'h08;

	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_MOVE = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] REG_CURSOR_ENABLE = 2'd0;
	localparam logic [1:0] REG_CURSOR_GLYPH = 2'd1;
	localparam logic [1:0] REG_TAB_SPACING = 2'd2;

	// control bundle broadcast from the sequencer to every row cell
	typedef struct packed {
		logic       wr_en;
		logic [3:0] wr_row;
		logic [3:0] wr_col;
		logic [7:0] wr_data;
		logic       scroll;
		logic       rotate;
	} ttfb_ctl_t;
endpackage
`default_nettype wire

@@ sv/ttfb_cell.sv @@
// One screen row: characters and dirty mask, loaded from its lower neighbor.
`default_nettype none
module ttfb_cell
	import ttfb_pkg::*;
#(
	parameter int COLUMNS = 16,
	parameter int ROW = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ttfb_ctl_t            ctl,
	input  wire logic [COLUMNS*8-1:0] nb_chars,
	input  wire logic [COLUMNS-1:0]   nb_mask,
	output logic      [COLUMNS*8-1:0] chars,
	output logic      [COLUMNS-1:0]   mask
);
	logic [COLUMNS*8-1:0] chars_q;
	logic [COLUMNS-1:0]   mask_q;
	logic                 hit;

	assign hit = ctl.wr_en && (ctl.wr_row == 4'(ROW));

	// shift from neighbor, or write one byte of this row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= {COLUMNS{SPACE_CODE}};
			mask_q <= '0;
		end else if (ctl.rotate) begin
			chars_q <= nb_chars;
			mask_q <= nb_mask;
		end else if (ctl.scroll) begin
			chars_q <= nb_chars;
			mask_q <= '1;
		end else if (hit) begin
			for (int c = 0; c < COLUMNS; c++) begin
				if (ctl.wr_col == 4'(c)) begin
					chars_q[c*8 +: 8] <= ctl.wr_data;
					mask_q[c] <= 1'b1;
				end
			end
		end
	end

	assign chars = chars_q;
	assign mask = mask_q;
endmodule
`default_nettype wire

@@ sv/text_terminal_framebuffer_core.sv @@
// Top level: command sequencer over a chain of row cells.
// A put or a move steps through WR1, FIX and GLYPH; a tab first steps in TAB up to the next tab stop.
// A flush latches the dirty rows in FLSTART, then in FLUSH the row chain rotates once
// through row 0 and each dirty row comes out on a one-cycle strobe. The last strobe can come
// while busy is already low. The receiver cannot stall: results are shown for exactly one
// cycle each. The config port is always ready.
`default_nettype none
module text_terminal_framebuffer_core
	import ttfb_pkg::*;
#(
	parameter int COLUMNS = 16,
	parameter int LINES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  character,
	input  wire logic        flush_after,
	input  wire logic [3:0]  move_column,
	input  wire logic [3:0]  move_row,
	output logic             strobe,
	output logic [3:0]       row_index,
	output logic [15:0]      dirty_mask,
	output logic [63:0]      chars_low,
	output logic [63:0]      chars_high,
	output logic             last_row,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	localparam logic [5:0] COLS6 = 6'(COLUMNS);
	localparam logic [4:0] LINES5 = 5'(LINES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WR1 = 3'd1;
	localparam logic [2:0] S_TAB = 3'd2;
	localparam logic [2:0] S_FIX = 3'd3;
	localparam logic [2:0] S_GLYPH = 3'd4;
	localparam logic [2:0] S_FLSTART = 3'd5;
	localparam logic [2:0] S_FLUSH = 3'd6;

	logic [2:0]  state_q;
	logic        en_q;
	logic [7:0]  glyph_q;
	logic [4:0]  tab_q;
	logic [1:0]  cmd_q;
	logic [7:0]  ch_q;
	logic        fa_q;
	logic [3:0]  mc_q;
	logic [3:0]  mr_q;
	logic [3:0]  cx_q;
	logic [3:0]  cy_q;
	logic [5:0]  nx_q;
	logic [4:0]  ny_q;
	logic [5:0]  t_q;
	logic        fl_req_q;
	logic [LINES:0] dirty_q;
	logic [4:0]  cnt_q;
	logic        strobe_q;
	logic        last_q;
	logic [3:0]  row_q;
	logic [15:0] mask_q;
	logic [127:0] chars_q;

	ttfb_ctl_t   ctl;
	logic [4:0]  ts;
	logic [5:0]  fx_x;
	logic [4:0]  fx_y;
	logic        do_scroll;
	logic [LINES-1:0] dirty_vec;
	logic [127:0] pad_chars;
	logic [15:0] pad_mask;

	logic [COLUMNS*8-1:0] row_chars [LINES];
	logic [COLUMNS-1:0]   row_mask [LINES];
	logic [COLUMNS*8-1:0] nb_chars [LINES];
	logic [COLUMNS-1:0]   nb_mask [LINES];

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);
	assign ts = (tab_q == 5'd0) ? 5'd1 : tab_q;

	// take configuration beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			glyph_q <= 8'd95;
			tab_q <= 5'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CURSOR_ENABLE: en_q <= cfg_data[0];
				REG_CURSOR_GLYPH: glyph_q <= cfg_data;
				REG_TAB_SPACING: tab_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// wrap and scroll check on the pending cursor
	always_comb begin
		fx_x = nx_q;
		fx_y = ny_q;
		if (nx_q >= COLS6) begin
			fx_x = 6'd0;
			fx_y = ny_q + 5'd1;
		end
		do_scroll = (fx_y >= LINES5);
		if (do_scroll) fx_y = LINES5 - 5'd1;
	end

	// drive cell controls from the sequencer state
	always_comb begin
		ctl = '0;
		case (state_q)
			S_WR1: begin
				if (cmd_q == CMD_PUT) begin
					if (ch_q >= SPACE_CODE) begin
						ctl.wr_en = 1'b1;
						ctl.wr_data = ch_q;
						ctl.wr_col = cx_q;
					end else if (ch_q == CH_LF || ch_q == CH_TAB) begin
						ctl.wr_en = en_q;
						ctl.wr_data = SPACE_CODE;
						ctl.wr_col = cx_q;
					end else if (ch_q == CH_BS) begin
						ctl.wr_en = (cx_q != 4'd0);
						ctl.wr_data = SPACE_CODE;
						ctl.wr_col = cx_q - 4'd1;
					end
				end else begin
					ctl.wr_en = en_q;
					ctl.wr_data = SPACE_CODE;
					ctl.wr_col = cx_q;
				end
				ctl.wr_row = cy_q;
			end
			S_FIX: ctl.scroll = do_scroll;
			S_GLYPH: begin
				ctl.wr_en = en_q;
				ctl.wr_data = glyph_q;
				ctl.wr_col = cx_q;
				ctl.wr_row = cy_q;
			end
			S_FLUSH: ctl.rotate = 1'b1;
			default: ;
		endcase
	end

	// chain of row cells, each fed by the row below, the bottom row by row 0 or by spaces
	for (genvar i = 0; i < LINES; i++) begin : g_row
		if (i < LINES - 1) begin : g_mid
			assign nb_chars[i] = row_chars[i+1];
			assign nb_mask[i] = row_mask[i+1];
		end else begin : g_bot
			assign nb_chars[i] = ctl.rotate ? row_chars[0] : {COLUMNS{SPACE_CODE}};
			assign nb_mask[i] = '0;
		end
		assign dirty_vec[i] = |row_mask[i];
		ttfb_cell #(.COLUMNS(COLUMNS), .ROW(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.nb_chars(nb_chars[i]), .nb_mask(nb_mask[i]),
			.chars(row_chars[i]), .mask(row_mask[i])
		);
	end

	// zero-extend row 0 to the full result width
	always_comb begin
		pad_chars = '0;
		pad_chars[COLUMNS*8-1:0] = row_chars[0];
		pad_mask = '0;
		pad_mask[COLUMNS-1:0] = row_mask[0];
	end

	// sequence one command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cx_q <= 4'd0;
			cy_q <= 4'd0;
			strobe_q <= 1'b0;
			fl_req_q <= 1'b0;
			cnt_q <= 5'd0;
			dirty_q <= '0;
		end else begin
			strobe_q <= (state_q == S_FLUSH) && dirty_q[0];
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						ch_q <= character;
						fa_q <= flush_after;
						mc_q <= move_column;
						mr_q <= move_row;
						if (command == CMD_PUT || command == CMD_MOVE) state_q <= S_WR1;
						else if (command == CMD_FLUSH) state_q <= S_FLSTART;
					end
				end
				S_WR1: begin
					if (cmd_q == CMD_PUT) begin
						fl_req_q <= fa_q;
						if (ch_q >= SPACE_CODE) begin
							nx_q <= {2'b0, cx_q} + 6'd1;
							ny_q <= {1'b0, cy_q};
							state_q <= S_FIX;
						end else if (ch_q == CH_LF) begin
							nx_q <= 6'd0;
							ny_q <= {1'b0, cy_q} + 5'd1;
							state_q <= S_FIX;
						end else if (ch_q == CH_TAB) begin
							ny_q <= {1'b0, cy_q};
							t_q <= 6'd0;
							state_q <= S_TAB;
						end else if (ch_q == CH_BS && cx_q != 4'd0) begin
							nx_q <= {2'b0, cx_q} - 6'd1;
							ny_q <= {1'b0, cy_q};
							state_q <= S_FIX;
						end else begin
							nx_q <= {2'b0, cx_q};
							ny_q <= {1'b0, cy_q};
							state_q <= S_FIX;
						end
					end else begin
						fl_req_q <= en_q | fa_q;
						nx_q <= ({2'b0, mc_q} < COLS6) ? {2'b0, mc_q} : COLS6 - 6'd1;
						ny_q <= ({1'b0, mr_q} < LINES5) ? {1'b0, mr_q} : LINES5 - 5'd1;
						state_q <= S_FIX;
					end
				end
				S_TAB: begin
					// step up to the first tab stop past the cursor
					if (t_q <= {2'b0, cx_q}) t_q <= t_q + {1'b0, ts};
					else begin
						nx_q <= t_q;
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					cx_q <= fx_x[3:0];
					cy_q <= fx_y[3:0];
					state_q <= S_GLYPH;
				end
				S_GLYPH: state_q <= fl_req_q ? S_FLSTART : S_IDLE;
				S_FLSTART: begin
					dirty_q <= {1'b0, dirty_vec};
					cnt_q <= 5'd0;
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					last_q <= (dirty_q[LINES:1] == '0);
					row_q <= cnt_q[3:0];
					mask_q <= pad_mask;
					chars_q <= pad_chars;
					dirty_q <= dirty_q >> 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LINES5 - 5'd1) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign row_index = row_q;
	assign dirty_mask = mask_q;
	assign chars_low = chars_q[63:0];
	assign chars_high = chars_q[127:64];
	assign last_row = strobe_q & last_q;

	a_strobe_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == S_FLUSH) else $error("result outside flush walk");
	a_cursor_col: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cx_q} < 5'(COLUMNS)) else $error("cursor column off screen");
	a_cursor_row: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cy_q} < LINES5) else $error("cursor row off screen");
	a_scroll_not_rotate: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.scroll && ctl.rotate)) else $error("scroll during flush walk");
endmodule
`default_nettype wire

@@ verif/text_terminal_framebuffer_core_tb.sv @@
// Self-checking testbench of the text terminal framebuffer core.
`timescale 1ns / 100ps
`default_nettype none
module text_terminal_framebuffer_core_tb;
	import ttfb_pkg::*;

	localparam int NCOL = 16;
	localparam int NROW = 8;
	localparam int SETTLE = 40;
	localparam int WATCHDOG = 3000;

	typedef struct packed {
		logic [3:0]  row;
		logic [15:0] mask;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        last;
	} row_dump_t;

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic       fa;
		logic [3:0] mc;
		logic [3:0] mr;
		bit         typed;
		int         tcount;
		row_dump_t  tres;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = CMD_PUT;
	logic [7:0]  character = 8'h00;
	logic        flush_after = 1'b0;
	logic [3:0]  move_column = 4'd0;
	logic [3:0]  move_row = 4'd0;
	logic        strobe;
	logic [3:0]  row_index;
	logic [15:0] dirty_mask;
	logic [63:0] chars_low;
	logic [63:0] chars_high;
	logic        last_row;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_CURSOR_ENABLE;
	logic [7:0]  cfg_data = 8'h00;

	text_terminal_framebuffer_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .character(character), .flush_after(flush_after),
		.move_column(move_column), .move_row(move_row),
		.strobe(strobe), .row_index(row_index), .dirty_mask(dirty_mask),
		.chars_low(chars_low), .chars_high(chars_high), .last_row(last_row),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// shadow screen state
	logic [7:0]  screen [NROW][NCOL];
	logic [15:0] marks [NROW];
	int          cur_x, cur_y;
	logic        show_cursor;
	logic [7:0]  glyph;
	logic [4:0]  tab_step;

	row_dump_t   pending_rows [$];
	row_dump_t   scratch [$];
	int          errors = 0;
	int          n_items = 0;
	int          n_rows = 0;
	int          quiet = 0;
	bit          no_idle = 0;

	function automatic void paint(int x, int y, logic [7:0] code);
		if (x < NCOL && y < NROW) begin
			screen[y][x] = code;
			marks[y][x] = 1'b1;
		end
	endfunction

	function automatic void dump_dirty();
		row_dump_t r;
		int n;
		n = 0;
		for (int y = 0; y < NROW; y++) begin
			if (marks[y] != 16'h0) begin
				r.row = y[3:0];
				r.mask = marks[y];
				r.lo = '0;
				r.hi = '0;
				for (int x = 0; x < NCOL; x++) begin
					if (x < 8)
						r.lo[8*x +: 8] = screen[y][x];
					else
						r.hi[8*(x-8) +: 8] = screen[y][x];
				end
				r.last = 1'b0;
				marks[y] = 16'h0;
				scratch.push_back(r);
				n++;
			end
		end
		if (n > 0)
			scratch[scratch.size()-1].last = 1'b1;
	endfunction

	function automatic void type_char(logic [7:0] ch);
		int x, y, ts;
		x = cur_x;
		y = cur_y;
		ts = (tab_step == 0) ? 1 : int'(tab_step);
		if (ch >= SPACE_CODE) begin
			paint(x, y, ch);
			x++;
		end else if (ch == CH_LF) begin
			if (show_cursor)
				paint(x, y, SPACE_CODE);
			x = 0;
			y++;
		end else if (ch == CH_TAB) begin
			if (show_cursor)
				paint(x, y, SPACE_CODE);
			x = (x / ts + 1) * ts;
		end else if (ch == CH_BS) begin
			if (x > 0) begin
				x--;
				paint(x, y, SPACE_CODE);
			end
		end
		if (x >= NCOL) begin
			y++;
			x = 0;
		end
		// scroll the whole screen up one row
		if (y >= NROW) begin
			for (int r = 0; r < NROW - 1; r++)
				screen[r] = screen[r+1];
			for (int c = 0; c < NCOL; c++)
				screen[NROW-1][c] = SPACE_CODE;
			for (int r = 0; r < NROW; r++)
				marks[r] = 16'hFFFF;
			y = NROW - 1;
		end
		cur_x = x;
		cur_y = y;
		if (show_cursor)
			paint(x, y, glyph);
	endfunction

	// apply one command beat to the shadow screen, leaving its row dumps in scratch
	function automatic void run_command(logic [1:0] cmd, logic [7:0] ch, logic fa,
			logic [3:0] mc, logic [3:0] mr);
		scratch.delete();
		if (cmd == CMD_PUT) begin
			type_char(ch);
			if (fa)
				dump_dirty();
		end else if (cmd == CMD_MOVE) begin
			if (show_cursor)
				paint(cur_x, cur_y, SPACE_CODE);
			cur_x = (mc < NCOL) ? int'(mc) : NCOL - 1;
			cur_y = (mr < NROW) ? int'(mr) : NROW - 1;
			if (show_cursor)
				paint(cur_x, cur_y, glyph);
			if (show_cursor || fa)
				dump_dirty();
		end else if (cmd == CMD_FLUSH) begin
			dump_dirty();
		end
	endfunction

	// check each row beat against the oldest expectation
	always @(posedge clk) begin
		row_dump_t e;
		if (arst_n && strobe) begin
			n_rows++;
			if (pending_rows.size() == 0) begin
				errors++;
				$display("%0t: unexpected row beat row=%0d", $time, row_index);
			end else begin
				e = pending_rows.pop_front();
				if (row_index !== e.row) begin
					errors++;
					$display("%0t: row_index exp %0d got %0d", $time, e.row, row_index);
				end
				if (dirty_mask !== e.mask) begin
					errors++;
					$display("%0t: dirty_mask exp %h got %h", $time, e.mask, dirty_mask);
				end
				if (chars_low !== e.lo) begin
					errors++;
					$display("%0t: chars_low exp %h got %h", $time, e.lo, chars_low);
				end
				if (chars_high !== e.hi) begin
					errors++;
					$display("%0t: chars_high exp %h got %h", $time, e.hi, chars_high);
				end
				if (last_row !== e.last) begin
					errors++;
					$display("%0t: last_row exp %b got %b", $time, e.last, last_row);
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || strobe)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	// unless no_idle is set, at random drop start and idle for a random stretch
	task automatic idle_gap();
		int n;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 14);
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rows.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_CURSOR_ENABLE)
			show_cursor = val[0];
		else if (idx == REG_CURSOR_GLYPH)
			glyph = val;
		else if (idx == REG_TAB_SPACING)
			tab_step = val[4:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// start stays high after the beat until the next beat, an idle stretch or a drain
	task automatic send_beat(cmd_row_t b);
		idle_gap();
		start <= 1'b1;
		command <= b.cmd;
		character <= b.ch;
		flush_after <= b.fa;
		move_column <= b.mc;
		move_row <= b.mr;
		do @(posedge clk); while (busy);
		run_command(b.cmd, b.ch, b.fa, b.mc, b.mr);
		if (b.typed) begin
			if (b.tcount > 0)
				pending_rows.push_back(b.tres);
		end else begin
			foreach (scratch[i])
				pending_rows.push_back(scratch[i]);
		end
		n_items++;
		@(negedge clk);
	endtask

	function automatic cmd_row_t random_beat();
		cmd_row_t b;
		int pick;
		b.typed = 0;
		b.tcount = 0;
		b.tres = '0;
		b.ch = 8'($urandom);
		b.mc = 4'($urandom);
		b.mr = 4'($urandom);
		b.fa = ($urandom_range(0, 4) == 0);
		pick = $urandom_range(0, 99);
		b.cmd = CMD_PUT;
		if (pick < 45) begin
			b.ch = 8'($urandom_range(32, 255));
		end else if (pick < 55) begin
			b.ch = CH_LF;
		end else if (pick < 63) begin
			b.ch = CH_TAB;
		end else if (pick < 71) begin
			b.ch = CH_BS;
		end else if (pick < 76) begin
			b.ch = 8'($urandom_range(0, 31));
		end else if (pick < 88) begin
			b.cmd = CMD_MOVE;
		end else if (pick < 97) begin
			b.cmd = CMD_FLUSH;
		end else begin
			b.cmd = 2'd3;
		end
		return b;
	endfunction

	cmd_row_t opening [$] = '{
		'{CMD_PUT, 8'h41, 1'b1, 4'd0, 4'd0, 1, 1,
			'{4'd0, 16'h0001, 64'h2020202020202041, 64'h2020202020202020, 1'b1}},
		'{CMD_FLUSH, 8'h00, 1'b1, 4'd0, 4'd0, 1, 0, '0},
		'{CMD_PUT, 8'hFF, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, 8'h20, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, 8'h1F, 1'b1, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_TAB, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_TAB, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_BS, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_LF, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_BS, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, 8'h78, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_BS, 1'b1, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_MOVE, 8'h00, 1'b1, 4'd15, 4'd15, 0, 0, '0},
		'{CMD_PUT, 8'h7A, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_FLUSH, 8'h00, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_MOVE, 8'h00, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{2'd3, 8'hFF, 1'b1, 4'd15, 4'd15, 0, 0, '0},
		'{CMD_PUT, 8'h00, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_FLUSH, 8'h00, 1'b1, 4'd0, 4'd0, 0, 0, '0}
	};

	cmd_row_t cursor_rows [$] = '{
		'{CMD_MOVE, 8'h00, 1'b0, 4'd3, 4'd2, 0, 0, '0},
		'{CMD_PUT, CH_TAB, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_LF, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, CH_BS, 1'b0, 4'd0, 4'd0, 0, 0, '0},
		'{CMD_PUT, 8'h71, 1'b1, 4'd0, 4'd0, 0, 0, '0}
	};

	initial begin
		for (int y = 0; y < NROW; y++) begin
			marks[y] = 16'h0;
			for (int x = 0; x < NCOL; x++)
				screen[y][x] = SPACE_CODE;
		end
		cur_x = 0;
		cur_y = 0;
		show_cursor = 1'b0;
		glyph = 8'd95;
		tab_step = 5'd8;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset values, extremes and control codes
		foreach (opening[i])
			send_beat(opening[i]);

		// cursor drawn, tab past the line end
		write_reg(REG_CURSOR_ENABLE, 8'd1);
		write_reg(REG_CURSOR_GLYPH, 8'hFF);
		write_reg(REG_TAB_SPACING, 8'd16);
		foreach (cursor_rows[i])
			send_beat(cursor_rows[i]);
		write_reg(REG_TAB_SPACING, 8'd0);
		send_beat(cursor_rows[1]);
		write_reg(REG_TAB_SPACING, 8'd31);
		send_beat(cursor_rows[1]);

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_CURSOR_ENABLE, 8'($urandom_range(0, 1)));
			write_reg(REG_CURSOR_GLYPH, (ph == 0) ? 8'h00 : 8'($urandom));
			write_reg(REG_TAB_SPACING, (ph == 1) ? 8'd1 : 8'($urandom_range(0, 31)));
			no_idle = (ph == 5);
			for (int k = 0; k < 24; k++) begin
				if (ph == 2 && k == 12) begin
					// hold off until every row dump has come back
					start <= 1'b0;
					while (pending_rows.size() != 0 || busy)
						@(negedge clk);
				end
				send_beat(random_beat());
			end
		end

		drain();
		$display("covered %0d command beats and %0d row dumps", n_items, n_rows);
		$display("cursor on and off, tab spacings 0 to 31, scrolls, wraps and clamped moves");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
